### design/assert_macros.svh
// Assertion helpers shared by the design modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define LSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, active in every cycle
`define LSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/lsi_pkg.sv
package lsi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IW          = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int IDX_W       = 8;
    localparam int XW          = 32;
    localparam int INT_W       = 48;
    localparam int PROD_W      = 2 * (XW + 1);
    localparam int ACC_W       = PROD_W + IW + 2;
    localparam int FRAC_SH     = 17;
    localparam int SHW         = ACC_W - FRAC_SH;
    localparam int DIV_N       = PROD_W - 1;
    localparam int DCW         = $clog2(DIV_N + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SEG,
        S_MUL,
        S_DIV,
        S_IV,
        S_IRD,
        S_IMUL,
        S_IACC,
        S_LMUL,
        S_LACC,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LO,
        RD_IT
    } t_rdsel;

    typedef struct packed {
        logic   load_we;
        logic   q_start;
        logic   rd_en;
        t_rdsel rd_sel;
        logic   srch_upd;
        logic   seg_mul;
        logic   div_start;
        logic   div_step;
        logic   iv_calc;
        logic   trap_mul;
        logic   last_mul;
        logic   acc_add;
        logic   it_inc;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic span_gt1;
        logic seg_zero;
        logic div_done;
        logic it_lt_lo;
    } t_stat;

endpackage

### design/lsi_ctrl.sv
`include "assert_macros.svh"

module lsi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_s_kind,
    input  logic           i_m_ready,
    input  lsi_pkg::t_stat i_stat,
    output logic           o_s_ready,
    output logic           o_m_valid,
    output lsi_pkg::t_cmd  o_cmd
);

    lsi_pkg::t_state r_state, n_state;
    logic            r_ovalid, n_ovalid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsi_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Write a load while idle; sequence a query through search, division and trapezoid sum
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.rd_sel = lsi_pkg::RD_MID;
        o_s_ready = 1'b0;
        unique case (r_state)
            lsi_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_s_kind == lsi_pkg::CMD_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.q_start = 1'b1;
                        n_state = lsi_pkg::S_SRCH;
                    end
                end
            end
            lsi_pkg::S_SRCH: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.span_gt1) begin
                    o_cmd.rd_sel = lsi_pkg::RD_MID;
                    n_state = lsi_pkg::S_CMP;
                end else begin
                    o_cmd.rd_sel = lsi_pkg::RD_LO;
                    n_state = lsi_pkg::S_SEG;
                end
            end
            lsi_pkg::S_CMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state = lsi_pkg::S_SRCH;
            end
            lsi_pkg::S_SEG: begin
                o_cmd.seg_mul = 1'b1;
                n_state = lsi_pkg::S_MUL;
            end
            lsi_pkg::S_MUL: begin
                if (i_stat.seg_zero) begin
                    n_state = lsi_pkg::S_IRD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = lsi_pkg::S_DIV;
                end
            end
            lsi_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = lsi_pkg::S_IV;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            lsi_pkg::S_IV: begin
                o_cmd.iv_calc = 1'b1;
                n_state = lsi_pkg::S_IRD;
            end
            lsi_pkg::S_IRD: begin
                if (i_stat.it_lt_lo) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = lsi_pkg::RD_IT;
                    n_state = lsi_pkg::S_IMUL;
                end else begin
                    n_state = lsi_pkg::S_LMUL;
                end
            end
            lsi_pkg::S_IMUL: begin
                o_cmd.trap_mul = 1'b1;
                n_state = lsi_pkg::S_IACC;
            end
            lsi_pkg::S_IACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.it_inc  = 1'b1;
                n_state = lsi_pkg::S_IRD;
            end
            lsi_pkg::S_LMUL: begin
                o_cmd.last_mul = 1'b1;
                n_state = lsi_pkg::S_LACC;
            end
            lsi_pkg::S_LACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = lsi_pkg::S_FIN;
            end
            lsi_pkg::S_FIN: begin
                // Load the output register once the previous result is gone
                if (!r_ovalid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = lsi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsi_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_ready) begin
            n_ovalid = 1'b0;
        end
    end

    assign o_m_valid = r_ovalid;

    `LSI_ASSERT(a_fin_free, i_clk, i_rst_n, (r_state == lsi_pkg::S_FIN) && !r_ovalid |=> (r_state == lsi_pkg::S_IDLE) && r_ovalid, "finished result not loaded into free output register")

endmodule

### design/lsi_dp.sv
`include "assert_macros.svh"

module lsi_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsi_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  logic [lsi_pkg::IDX_W-1:0]         i_idx,
    input  logic signed [lsi_pkg::XW-1:0]     i_x,
    input  logic signed [lsi_pkg::XW-1:0]     i_y,
    input  lsi_pkg::t_cmd                     i_cmd,
    output lsi_pkg::t_stat                    o_stat,
    output logic signed [lsi_pkg::XW-1:0]     o_interp,
    output logic signed [lsi_pkg::INT_W-1:0]  o_integral,
    output logic [1:0]                        o_status
);

    localparam int XW  = lsi_pkg::XW;
    localparam int IW  = lsi_pkg::IW;
    localparam int PW  = lsi_pkg::PROD_W;
    localparam int AW  = lsi_pkg::ACC_W;
    localparam int SW  = lsi_pkg::SHW;
    localparam int OW  = lsi_pkg::INT_W;
    localparam int DN  = lsi_pkg::DIV_N;
    localparam int DCW = lsi_pkg::DCW;

    logic signed [XW-1:0] mem_x [lsi_pkg::TABLE_DEPTH];
    logic signed [XW-1:0] mem_y [lsi_pkg::TABLE_DEPTH];

    logic [lsi_pkg::CNT_W-1:0] r_count;
    logic [IW-1:0]             r_lo, r_hi, r_it;
    logic signed [XW-1:0]      r_z, r_xa, r_xb, r_ya, r_yb, r_x0, r_y0, r_iv;
    logic [XW:0]               r_dx_mag;
    logic                      r_dx_neg, r_zero, r_neg, r_sat;
    logic signed [PW-1:0]      r_prod;
    logic [DN-1:0]             r_div_q;
    logic [XW:0]               r_div_r;
    logic [DCW-1:0]            r_div_cnt;
    logic signed [AW-1:0]      r_acc;
    logic signed [XW-1:0]      r_out_interp;
    logic signed [OW-1:0]      r_out_integral;
    logic [1:0]                r_out_status;

    logic [IW-1:0]        w_hi_init, w_mid, w_addr, w_addr_b;
    logic [IW:0]          w_sum;
    logic signed [XW:0]   w_ma, w_mb, w_dx;
    logic [DN-1:0]        w_pmag;
    logic [XW+1:0]        w_trial;
    logic signed [XW+2:0] w_ivs, w_qs;
    logic signed [SW-1:0] w_sh;
    logic                 w_isat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= lsi_pkg::CNT_W'(2);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Clamp the point count to the table and take the upper search bound
    always_comb begin
        if (r_count < lsi_pkg::CNT_W'(2)) begin
            w_hi_init = IW'(1);
        end else if (int'(r_count) > lsi_pkg::TABLE_DEPTH) begin
            w_hi_init = IW'(lsi_pkg::TABLE_DEPTH - 1);
        end else begin
            w_hi_init = IW'(r_count - lsi_pkg::CNT_W'(1));
        end
    end

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[IW:1];

    // Select the read address for both ports of each table
    always_comb begin
        case (i_cmd.rd_sel)
            lsi_pkg::RD_MID: w_addr = w_mid;
            lsi_pkg::RD_LO:  w_addr = r_lo;
            lsi_pkg::RD_IT:  w_addr = r_it;
            default:         w_addr = r_lo;
        endcase
    end
    assign w_addr_b = w_addr + IW'(1);

    // Point tables: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (int'(i_idx) < lsi_pkg::TABLE_DEPTH)) begin
            mem_x[IW'(i_idx)] <= i_x;
            mem_y[IW'(i_idx)] <= i_y;
        end
        if (i_cmd.rd_en) begin
            r_xa <= mem_x[w_addr];
            r_xb <= mem_x[w_addr_b];
            r_ya <= mem_y[w_addr];
            r_yb <= mem_y[w_addr_b];
        end
    end

    // Search bounds and trapezoid index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= IW'(1);
            r_it <= '0;
        end else if (i_cmd.q_start) begin
            r_lo <= '0;
            r_hi <= w_hi_init;
            r_it <= '0;
        end else begin
            if (i_cmd.srch_upd) begin
                if (r_xa > r_z) begin
                    r_hi <= w_mid;
                end else begin
                    r_lo <= w_mid;
                end
            end
            if (i_cmd.it_inc) begin
                r_it <= r_it + IW'(1);
            end
        end
    end

    // Shared signed multiplier operands
    assign w_dx = (XW + 1)'(r_xb) - (XW + 1)'(r_xa);
    always_comb begin
        w_ma = (XW + 1)'(r_yb) - (XW + 1)'(r_ya);
        w_mb = (XW + 1)'(r_z) - (XW + 1)'(r_xa);
        if (i_cmd.trap_mul) begin
            w_ma = (XW + 1)'(r_ya) + (XW + 1)'(r_yb);
            w_mb = w_dx;
        end else if (i_cmd.last_mul) begin
            w_ma = (XW + 1)'(r_iv) + (XW + 1)'(r_y0);
            w_mb = (XW + 1)'(r_z) - (XW + 1)'(r_x0);
        end
    end

    assign w_pmag = r_prod[PW-1] ? DN'(-r_prod) : DN'(r_prod);
    assign w_trial = {r_div_r, r_div_q[DN-1]};

    // Interpolated value from the quotient, saturated to 32 bits
    assign w_qs  = {2'b00, r_div_q[XW:0]};
    assign w_ivs = r_neg ? (XW + 3)'(r_y0) - w_qs : (XW + 3)'(r_y0) + w_qs;

    // Segment, multiply, divide and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_z   <= i_x;
            r_acc <= '0;
        end
        if (i_cmd.seg_mul) begin
            r_x0     <= r_xa;
            r_y0     <= r_ya;
            r_iv     <= r_ya;
            r_zero   <= (w_dx == '0);
            r_dx_neg <= w_dx[XW];
            r_dx_mag <= w_dx[XW] ? (XW + 1)'(-w_dx) : (XW + 1)'(w_dx);
            r_sat    <= 1'b0;
        end
        if (i_cmd.seg_mul || i_cmd.trap_mul || i_cmd.last_mul) begin
            r_prod <= PW'(w_ma) * PW'(w_mb);
        end
        if (i_cmd.div_start) begin
            r_div_q   <= w_pmag;
            r_div_r   <= '0;
            r_neg     <= r_prod[PW-1] ^ r_dx_neg;
            r_div_cnt <= DCW'(DN);
        end else if (i_cmd.div_step) begin
            // Restoring division, one quotient bit per cycle
            if (w_trial >= {1'b0, r_dx_mag}) begin
                r_div_r <= (XW + 1)'(w_trial - {1'b0, r_dx_mag});
                r_div_q <= {r_div_q[DN-2:0], 1'b1};
            end else begin
                r_div_r <= w_trial[XW:0];
                r_div_q <= {r_div_q[DN-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
        if (i_cmd.iv_calc) begin
            if (|r_div_q[DN-1:XW+1]) begin
                r_sat <= 1'b1;
                r_iv  <= r_neg ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
            end else if (w_ivs[XW+2:XW-1] != {4{w_ivs[XW-1]}}) begin
                r_sat <= 1'b1;
                r_iv  <= w_ivs[XW+2] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
            end else begin
                r_iv  <= w_ivs[XW-1:0];
            end
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    // Scale the doubled trapezoid sum to Q32.16, floor, and saturate
    assign w_sh   = SW'(r_acc >>> lsi_pkg::FRAC_SH);
    assign w_isat = (w_sh[SW-1:OW-1] != {(SW-OW+1){w_sh[OW-1]}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_interp <= r_iv;
            if (w_isat) begin
                r_out_integral <= w_sh[SW-1] ? {1'b1, {(OW-1){1'b0}}}
                                             : {1'b0, {(OW-1){1'b1}}};
            end else begin
                r_out_integral <= w_sh[OW-1:0];
            end
            if (r_sat || w_isat) begin
                r_out_status <= lsi_pkg::ST_SAT;
            end else if (r_zero) begin
                r_out_status <= lsi_pkg::ST_ZERO;
            end else begin
                r_out_status <= lsi_pkg::ST_OK;
            end
        end
    end

    assign o_stat.span_gt1 = (r_hi - r_lo) > IW'(1);
    assign o_stat.seg_zero = r_zero;
    assign o_stat.div_done = (r_div_cnt == '0);
    assign o_stat.it_lt_lo = (r_it < r_lo);
    assign o_interp   = r_out_interp;
    assign o_integral = r_out_integral;
    assign o_status   = r_out_status;

    `LSI_ASSERT(a_bounds, i_clk, i_rst_n, r_lo < r_hi, "search bounds crossed")
    `LSI_ASSERT(a_div_cnt, i_clk, i_rst_n, i_cmd.div_step |-> (r_div_cnt != '0), "divider stepped past its last bit")

endmodule

### design/linear_spline_interp_integrate.sv
// Piecewise-linear interpolation and trapezoid integration over a table of up to
// TABLE_DEPTH signed Q16.16 points. A load (tuser 0) writes one point and returns
// nothing. A query (tuser 1) returns the interpolated value at z, the integral
// from the first x to z in Q32.16 and a status. One item is worked at a time. A
// query runs a binary search through the table memory, the bit-serial divider
// (skipped for a zero-width segment), then one trapezoid per table segment below z
// through the shared multiplier and accumulator, and the last partial trapezoid.
// point_count is to be written only while the block is idle; the block itself
// does not enforce this. The table needs no clearing.
module linear_spline_interp_integrate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsi_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [71:0]                   s_axis_tdata,  // point_index, x_value, y_value
    input  logic [0:0]                    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [79:0]                   m_axis_tdata,  // interp_value, integral_value
    output logic [1:0]                    m_axis_tuser   // status
);

    lsi_pkg::t_cmd                    w_cmd;
    lsi_pkg::t_stat                   w_stat;
    logic signed [lsi_pkg::XW-1:0]    w_interp;
    logic signed [lsi_pkg::INT_W-1:0] w_integral;

    lsi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_kind  (s_axis_tuser[0]),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    lsi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_idx       (s_axis_tdata[7:0]),
        .i_x         (s_axis_tdata[39:8]),
        .i_y         (s_axis_tdata[71:40]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_interp    (w_interp),
        .o_integral  (w_integral),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {w_integral, w_interp};

endmodule

### verif/lsi_checker.sv
`timescale 1ns / 100ps

// Watch both streams, predict each query result and compare in order.
module lsi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] interp;
        logic [47:0] integral;
        logic [1:0]  status;
    } t_spline_result;

    logic [31:0]    pt_x [lsi_pkg::TABLE_DEPTH];
    logic [31:0]    pt_y [lsi_pkg::TABLE_DEPTH];
    logic [8:0]     points_used;
    t_spline_result spline_results_q [$];

    assign o_pending = spline_results_q.size();

    // Interpolate and integrate at z over the current table
    function automatic t_spline_result eval_spline(logic [31:0] z_raw);
        t_spline_result r;
        int n, lo, hi, mid, i;
        longint z, x0, x1, y0, y1, dx, dy, dz, iv;
        longint unsigned q, mdy, mdz, mdx;
        logic signed [127:0] acc, fa, fb, shr;
        bit sat, zero, neg;
        n = int'(points_used);
        if (n < 2) n = 2;
        if (n > lsi_pkg::TABLE_DEPTH) n = lsi_pkg::TABLE_DEPTH;
        z = longint'(signed'(z_raw));
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (hi + lo) / 2;
            if (longint'(signed'(pt_x[mid])) > z) hi = mid;
            else lo = mid;
        end
        x0 = longint'(signed'(pt_x[lo]));
        x1 = longint'(signed'(pt_x[lo+1]));
        y0 = longint'(signed'(pt_y[lo]));
        y1 = longint'(signed'(pt_y[lo+1]));
        dx = x1 - x0;
        zero = (dx == 0);
        sat = 0;
        iv = y0;
        if (!zero) begin
            dy = y1 - y0;
            dz = z - x0;
            mdy = (dy < 0) ? -dy : dy;
            mdz = (dz < 0) ? -dz : dz;
            mdx = (dx < 0) ? -dx : dx;
            q = (mdy * mdz) / mdx;
            neg = ((dy < 0) != (dz < 0)) != (dx < 0);
            if (q > 64'h1_FFFF_FFFF) begin
                sat = 1;
                iv = neg ? -64'sd2147483648 : 64'sd2147483647;
            end else begin
                iv = neg ? y0 - longint'(q) : y0 + longint'(q);
                if (iv > 64'sd2147483647) begin iv = 64'sd2147483647; sat = 1; end
                if (iv < -64'sd2147483648) begin iv = -64'sd2147483648; sat = 1; end
            end
        end
        // sum full trapezoids below the segment, then the partial one
        acc = '0;
        for (i = 0; i < lo; i++) begin
            fa = longint'(signed'(pt_y[i])) + longint'(signed'(pt_y[i+1]));
            fb = longint'(signed'(pt_x[i+1])) - longint'(signed'(pt_x[i]));
            acc = acc + fa * fb;
        end
        fa = iv + y0;
        fb = z - x0;
        acc = acc + fa * fb;
        shr = acc >>> lsi_pkg::FRAC_SH;
        if (shr > 128'sh7FFF_FFFF_FFFF) begin
            r.integral = 48'h7FFF_FFFF_FFFF;
            sat = 1;
        end else if (shr < -128'sh8000_0000_0000) begin
            r.integral = 48'h8000_0000_0000;
            sat = 1;
        end else begin
            r.integral = shr[47:0];
        end
        r.interp = iv[31:0];
        r.status = sat ? lsi_pkg::ST_SAT : (zero ? lsi_pkg::ST_ZERO : lsi_pkg::ST_OK);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_spline_result exp_r;
        if (!i_rst_n) begin
            points_used <= 9'd2;
            o_fail_count <= 0;
            spline_results_q.delete();
        end else begin
            if (i_cfg_we)
                points_used <= i_cfg_wdata;
            // load or predict on each input transfer
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == lsi_pkg::CMD_LOAD) begin
                    pt_x[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
                    pt_y[s_axis_tdata[7:0]] = s_axis_tdata[71:40];
                end else begin
                    spline_results_q.push_back(eval_spline(s_axis_tdata[39:8]));
                end
            end
            // compare each output transfer with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (spline_results_q.size() == 0) begin
                    $error("unexpected result transfer: tdata %h tuser %0d",
                           m_axis_tdata, m_axis_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = spline_results_q.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.interp ||
                        m_axis_tdata[79:32] !== exp_r.integral ||
                        m_axis_tuser !== exp_r.status) begin
                        if (m_axis_tdata[31:0] !== exp_r.interp)
                            $error("interp_value: expected %h, got %h",
                                   exp_r.interp, m_axis_tdata[31:0]);
                        if (m_axis_tdata[79:32] !== exp_r.integral)
                            $error("integral_value: expected %h, got %h",
                                   exp_r.integral, m_axis_tdata[79:32]);
                        if (m_axis_tuser !== exp_r.status)
                            $error("status: expected %0d, got %0d",
                                   exp_r.status, m_axis_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int ITEM_TARGET = 900;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          items_sent = 0;
    bit          send_burst = 0;
    bit          hold_output = 0;
    logic [31:0] tbl_x [lsi_pkg::TABLE_DEPTH];

    always #1 i_clk = ~i_clk;

    linear_spline_interp_integrate dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    lsi_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int wait_cycles, n_results;
        bit burst;
        n_results = 0;
        burst = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_output) begin
                repeat (600) @(negedge i_clk) m_axis_tready <= 0;
                hold_output = 0;
            end
            wait_cycles = burst ? 0 : $urandom_range(0, 11);
            repeat (wait_cycles) @(negedge i_clk) m_axis_tready <= 0;
            @(negedge i_clk) m_axis_tready <= 1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            n_results++;
            if (n_results % 40 == 0) burst = ~burst;
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(logic cmd, logic [7:0] idx, logic [31:0] xv, logic [31:0] yv);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk) s_axis_tvalid <= 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {yv, xv, idx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
        if (cmd == lsi_pkg::CMD_LOAD) tbl_x[idx] = xv;
    endtask

    // Drain all results, then let a trailing load finish
    task automatic drain();
        @(negedge i_clk) s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(logic [8:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk) i_cfg_we <= 0;
    endtask

    // Fill entries 0..n-1: ascending with some equal neighbors, or fully random
    task automatic fill_table(int n, bit wild);
        longint xcur;
        int k;
        xcur = -longint'($urandom_range(0, 32'h4000_0000));
        for (k = 0; k < n; k++) begin
            if (wild) begin
                send_item(lsi_pkg::CMD_LOAD, k[7:0], $urandom, $urandom);
            end else begin
                send_item(lsi_pkg::CMD_LOAD, k[7:0], xcur[31:0], $urandom);
                if ($urandom_range(0, 7) != 0)
                    xcur = xcur + $urandom_range(1, (n > 64) ? 32'h0010_0000 : 32'h0400_0000);
                if (xcur > 64'sd2147483647) xcur = 64'sd2147483647;
            end
        end
    endtask

    function automatic logic [31:0] pick_z(int n);
        case ($urandom_range(0, 5))
            0: return tbl_x[$urandom_range(0, n - 1)];
            1: return tbl_x[$urandom_range(0, n - 1)] + $urandom_range(0, 32'h0001_0000) - 32'h8000;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return $urandom;
            default: return tbl_x[0] + $urandom_range(0, tbl_x[n-1] - tbl_x[0]);
        endcase
    endfunction

    initial begin
        int phase, n_eff, n_q, k;
        logic [8:0] cnt;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // Directed: full-scale points, a zero-width segment, saturation
        write_count(9'd4);
        send_item(lsi_pkg::CMD_LOAD, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lsi_pkg::CMD_LOAD, 8'd1, 32'h8000_0000, 32'h8000_0000);
        send_item(lsi_pkg::CMD_LOAD, 8'd2, 32'h0000_0000, 32'h0000_0000);
        send_item(lsi_pkg::CMD_LOAD, 8'd3, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lsi_pkg::CMD_QUERY, 8'hFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h0000_0000, 32'h0);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h7FFF_FFFF, 32'h0);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'hFFFF_FFFF, 32'h0);
        send_item(lsi_pkg::CMD_LOAD, 8'd3, 32'h0000_0000, 32'h7FFF_FFFF);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h0000_0005, 32'h0);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h7FFF_FFFF, 32'h0);
        write_count(9'd2);
        send_item(lsi_pkg::CMD_LOAD, 8'd1, 32'h8000_0000, 32'h1234_5678);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h0001_0000, 32'h0);
        send_item(lsi_pkg::CMD_LOAD, 8'd0, 32'hFFFF_0000, 32'h0001_0000);
        send_item(lsi_pkg::CMD_LOAD, 8'd1, 32'h0001_0000, 32'h0003_0000);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h0000_8000, 32'h0);
        send_item(lsi_pkg::CMD_QUERY, 8'd0, 32'h7FFF_FFFF, 32'h0);

        // Random phases: mostly small tables, a few at and beyond full depth
        phase = 0;
        while (items_sent < ITEM_TARGET + 20) begin
            case (phase % 9)
                2: cnt = 9'd256;
                4: cnt = 9'd0;
                5: cnt = 9'd1;
                7: cnt = (phase == 7) ? 9'd511 : 9'd300;
                default: cnt = 9'($urandom_range(2, 14));
            endcase
            if (phase > 20 && cnt > 9'd255) cnt = 9'($urandom_range(2, 14));
            n_eff = (cnt < 2) ? 2 : ((cnt > 256) ? 256 : cnt);
            write_count(cnt);
            send_burst = (phase % 5 == 3);
            fill_table(n_eff, (phase % 6 == 5));
            if (phase == 3) hold_output = 1;
            n_q = $urandom_range(8, 30);
            for (k = 0; k < n_q; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(lsi_pkg::CMD_LOAD, 8'($urandom), $urandom, $urandom);
                else
                    send_item(lsi_pkg::CMD_QUERY, 8'($urandom), pick_z(n_eff), $urandom);
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/lsi_pkg.sv
design/lsi_ctrl.sv
design/lsi_dp.sv
design/linear_spline_interp_integrate.sv
verif/lsi_checker.sv
verif/tb.sv
